/* hdl/rmct_pkg.sv */
package rmct_pkg;

  // default geometry parameters
  localparam int unsigned DIM_BITS_DEF      = 12;
  localparam int unsigned BAND_ROWS_DEF     = 12;
  localparam int unsigned STRIP_HALF_DEF    = 20;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned THIRD_W    = 12;
  localparam int unsigned WEIGHT_W   = 9;
  localparam int unsigned MODE_W     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOR   = 3'd4;

  // region modes
  localparam logic [MODE_W-1:0] MODE_FULL     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TOP_HALF = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROW_BAND = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STRIP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NONE     = 3'd4;

  // reset values
  localparam logic [SIZE_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [THIRD_W-1:0]  THIRD_RST  = 12'd160;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  // reciprocal of three, exact for 13-bit values
  localparam logic [THIRD_W-1:0] RECIP3     = 12'd2731;
  localparam int unsigned        RECIP3_SHR = 13;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   frame_width;
    logic [SIZE_W-1:0]   frame_height;
    logic [THIRD_W-1:0]  height_third;
    logic [MODE_W-1:0]   effect_mode;
    logic [WEIGHT_W-1:0] blend_weight;
    logic [7:0]          tint_red;
    logic [7:0]          tint_green;
    logic [7:0]          tint_blue;
  } cfg_t;

  // p + (c - p) * a / 256, same as (p*(256-a) + c*a) >> 8
  function automatic logic [7:0] mix_channel(input logic [7:0] p, input logic [7:0] c,
                                             input logic [WEIGHT_W-1:0] a);
    logic signed [9:0]  diff;
    logic signed [9:0]  wgt;
    logic signed [19:0] prod;
    logic signed [19:0] sum;
    diff = $signed({2'b00, c}) - $signed({2'b00, p});
    wgt  = $signed({1'b0, a});
    prod = 20'(diff) * 20'(wgt);
    sum  = $signed({4'b0000, p, 8'h00}) + prod;
    return sum[15:8];
  endfunction

endpackage

/* hdl/rmct_cfg.sv */
module rmct_cfg #(
  parameter int unsigned DIM_BITS = rmct_pkg::DIM_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rmct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rmct_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output rmct_pkg::cfg_t                   cfg_o
);

  localparam logic [31:0] DIM_MAX = 32'(1) << DIM_BITS;

  rmct_pkg::cfg_t cfg_q, cfg_d;
  logic [rmct_pkg::SIZE_W-1:0]   size_raw, size_clamp;
  logic [rmct_pkg::WEIGHT_W-1:0] wgt_raw;
  logic [24:0]                   third_prod;

  // size clamp shared by width and height writes
  always_comb begin
    size_raw = cfg_data_i[rmct_pkg::SIZE_W-1:0];
    if (size_raw == '0) begin
      size_clamp = rmct_pkg::SIZE_W'(1);
    end else if ({19'd0, size_raw} > DIM_MAX) begin
      size_clamp = DIM_MAX[rmct_pkg::SIZE_W-1:0];
    end else begin
      size_clamp = size_raw;
    end
    third_prod = 25'(size_clamp) * 25'(rmct_pkg::RECIP3);
    wgt_raw    = cfg_data_i[rmct_pkg::WEIGHT_W-1:0];
  end

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmct_pkg::REG_FRAME_WIDTH: begin
          cfg_d.frame_width = size_clamp;
        end
        rmct_pkg::REG_FRAME_HEIGHT: begin
          cfg_d.frame_height = size_clamp;
          cfg_d.height_third = third_prod[24:rmct_pkg::RECIP3_SHR];
        end
        rmct_pkg::REG_EFFECT_MODE: begin
          cfg_d.effect_mode = cfg_data_i[rmct_pkg::MODE_W-1:0];
        end
        rmct_pkg::REG_BLEND_WEIGHT: begin
          cfg_d.blend_weight = (wgt_raw > rmct_pkg::WEIGHT_ONE) ? rmct_pkg::WEIGHT_ONE
                                                                : wgt_raw;
        end
        rmct_pkg::REG_TINT_COLOR: begin
          cfg_d.tint_red   = cfg_data_i[31:24];
          cfg_d.tint_green = cfg_data_i[23:16];
          cfg_d.tint_blue  = cfg_data_i[15:8];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= rmct_pkg::WIDTH_RST;
      cfg_q.frame_height <= rmct_pkg::HEIGHT_RST;
      cfg_q.height_third <= rmct_pkg::THIRD_RST;
      cfg_q.effect_mode  <= rmct_pkg::MODE_FULL;
      cfg_q.blend_weight <= '0;
      cfg_q.tint_red     <= '0;
      cfg_q.tint_green   <= '0;
      cfg_q.tint_blue    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/rmct_pos.sv */
module rmct_pos #(
  parameter int unsigned DIM_BITS         = rmct_pkg::DIM_BITS_DEF,
  parameter int unsigned BAND_ROWS        = rmct_pkg::BAND_ROWS_DEF,
  parameter int unsigned STRIP_HALF_WIDTH = rmct_pkg::STRIP_HALF_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rmct_pkg::cfg_t cfg_i,
  input  logic           step_i,
  output logic           tint_o,
  output logic           last_o
);

  localparam int unsigned CW = (DIM_BITS > rmct_pkg::SIZE_W) ? DIM_BITS : rmct_pkg::SIZE_W;
  localparam int unsigned RW = CW + 2;

  logic [DIM_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0]       col_x, row_x, width_last, height_last, h_half, h_third;
  logic [CW:0]         band_hi;
  logic signed [RW-1:0] x_s, w_half_s, strip_lo, strip_hi;
  logic                last_col, last_row;

  // end of row and end of frame, also when a size shrank under the counters
  always_comb begin
    col_x       = CW'(col_q);
    row_x       = CW'(row_q);
    width_last  = CW'(cfg_i.frame_width - rmct_pkg::SIZE_W'(1));
    height_last = CW'(cfg_i.frame_height - rmct_pkg::SIZE_W'(1));
    last_col    = col_x >= width_last;
    last_row    = row_x >= height_last;
  end

  // region bounds
  always_comb begin
    h_half   = CW'(cfg_i.frame_height >> 1);
    h_third  = CW'(cfg_i.height_third);
    band_hi  = (CW + 1)'(h_third) + (CW + 1)'(BAND_ROWS);
    x_s      = $signed(RW'(col_q));
    w_half_s = $signed(RW'(cfg_i.frame_width >> 1));
    strip_lo = w_half_s - $signed(RW'(STRIP_HALF_WIDTH));
    strip_hi = w_half_s + $signed(RW'(STRIP_HALF_WIDTH));
  end

  // region select
  always_comb begin
    unique case (cfg_i.effect_mode)
      rmct_pkg::MODE_FULL:     tint_o = 1'b1;
      rmct_pkg::MODE_TOP_HALF: tint_o = row_x < h_half;
      rmct_pkg::MODE_ROW_BAND: tint_o = (row_x > h_third) && ((CW + 1)'(row_x) < band_hi);
      rmct_pkg::MODE_STRIP:    tint_o = (x_s > strip_lo) && (x_s < strip_hi);
      rmct_pkg::MODE_NONE:     tint_o = 1'b0;
      default:                 tint_o = 1'b0;
    endcase
  end

  assign last_o = last_col && last_row;

  // raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + DIM_BITS'(1);
      end else begin
        col_d = col_q + DIM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* hdl/rmct_blend.sv */
module rmct_blend (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmct_pkg::cfg_t    cfg_i,
  input  logic              pix_valid_i,
  input  rmct_pkg::pix_in_t pix_i,
  input  logic              tint_i,
  input  logic              last_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rmct_pkg::pix_out_t out_data_o
);

  logic               out_valid_q;
  rmct_pkg::pix_out_t out_q, out_d;

  // output register frees when empty or taken
  assign ready_o = !out_valid_q || !out_stall_i;

  // per-channel mix toward the tint
  always_comb begin
    out_d.alpha_out = pix_i.alpha_in;
    out_d.frame_end = last_i;
    if (tint_i) begin
      out_d.red_out   = rmct_pkg::mix_channel(pix_i.red_in, cfg_i.tint_red, cfg_i.blend_weight);
      out_d.green_out = rmct_pkg::mix_channel(pix_i.green_in, cfg_i.tint_green,
                                              cfg_i.blend_weight);
      out_d.blue_out  = rmct_pkg::mix_channel(pix_i.blue_in, cfg_i.tint_blue,
                                              cfg_i.blend_weight);
    end else begin
      out_d.red_out   = pix_i.red_in;
      out_d.green_out = pix_i.green_in;
      out_d.blue_out  = pix_i.blue_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= pix_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && pix_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/region_masked_color_tint.sv */
// an accepted word is held in the input register, then in the result register that drives the output
// throughput: one word per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the output word is not taken
// reset: asynchronous, active low; clears the counters, the pipeline valid bits
// and loads the register defaults (640 x 480, whole frame, weight zero)
module region_masked_color_tint #(
  parameter int unsigned DIM_BITS         = rmct_pkg::DIM_BITS_DEF,
  parameter int unsigned BAND_ROWS        = rmct_pkg::BAND_ROWS_DEF,
  parameter int unsigned STRIP_HALF_WIDTH = rmct_pkg::STRIP_HALF_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rmct_pkg::pix_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rmct_pkg::pix_out_t              out_data_o
);

  rmct_pkg::cfg_t    cfg;
  rmct_pkg::pix_in_t s1_pix_q;
  logic              s1_valid_q, s1_tint_q, s1_last_q;
  logic              tint, last, s2_ready, in_accept, s1_load;

  rmct_cfg #(
    .DIM_BITS(DIM_BITS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  rmct_pos #(
    .DIM_BITS        (DIM_BITS),
    .BAND_ROWS       (BAND_ROWS),
    .STRIP_HALF_WIDTH(STRIP_HALF_WIDTH)
  ) u_pos (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .step_i(in_accept),
    .tint_o(tint),
    .last_o(last)
  );

  // input stage holds while the result stage is blocked
  assign s1_load    = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_load;
  assign in_accept  = in_valid_i && s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q  <= in_data_i;
      s1_tint_q <= tint;
      s1_last_q <= last;
    end
  end

  rmct_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pix_valid_i(s1_valid_q),
    .pix_i      (s1_pix_q),
    .tint_i     (s1_tint_q),
    .last_i     (s1_last_q),
    .ready_o    (s2_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* hdl/rmct_checker.sv */
module rmct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rmct_pkg::pix_out_t out_data_o
);

  // input is held back only when a finished word waits at the output
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side is free");

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // a waiting word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output word changed");

  // with the output free, an accepted word passes the input and result registers and comes out
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not appear");

endmodule

bind region_masked_color_tint rmct_checker u_rmct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
